### hw/rtl/dcs_pkg.sv
// shared constants and helpers for the dichromat color simulation pipeline
// decimal coefficient table and fixed-point conversion, no dependencies
package dcs_pkg;

  // decimal scale of the coefficient table
  localparam longint DEC_DEN = 64'sd100000000;

  // number of constant weights: two plane rows, then 575 nm and 475 nm matrices
  localparam int NUM_COEF = 24;
  localparam int NUM_GROUP = NUM_COEF / 3;

  // group indexes of three-term sums
  localparam int GRP_SQLE = 0;
  localparam int GRP_SELQ = 1;
  localparam int GRP_M575 = 2;
  localparam int GRP_M475 = 5;

  // weights scaled by 1e8, rows of three in r, g, b order
  localparam longint COEF_DEC [NUM_COEF] = '{
    64'sd999000,    64'sd6647390,   64'sd73170000,
    64'sd15338400,  64'sd31662400,  64'sd5713400,
    64'sd42633100,  64'sd87510200,  64'sd8012710,
    64'sd28110000,  64'sd57119500,  -64'sd3926270,
    -64'sd1770520,  64'sd2700840,   64'sd100247000,
    64'sd75810000,  64'sd145387000, -64'sd148060000,
    64'sd11853200,  64'sd28759500,  64'sd72550100,
    -64'sd746579,   64'sd4487110,   64'sd95430300
  };

  // decimal weight to fixed point, round half away from zero
  function automatic longint to_fixed(longint dec, int frac);
    longint mag;
    longint scaled;
    mag = (dec < 0) ? -dec : dec;
    scaled = (mag * (longint'(1) << frac) + DEC_DEN / 2) / DEC_DEN;
    return (dec < 0) ? -scaled : scaled;
  endfunction

endpackage

### hw/rtl/dcs_mul_stage.sv
// first pipeline stage: all constant products of the three input channels
// uses dcs_pkg for the coefficient table and fixed-point conversion
module dcs_mul_stage #(
  parameter int COEF_FRAC_BITS = 16,
  parameter int PW = COEF_FRAC_BITS + 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic [7:0]           red,
  input  logic [7:0]           green,
  input  logic [7:0]           blue,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic signed [PW-1:0] prod [dcs_pkg::NUM_COEF]
);
  import dcs_pkg::*;

  localparam int CW = COEF_FRAC_BITS + 2;

  logic                 valid_r;
  logic                 valid_nxt;
  logic                 load;
  logic signed [8:0]    chan [3];
  logic signed [PW-1:0] prod_nxt [NUM_COEF];
  logic signed [PW-1:0] prod_r [NUM_COEF];

  // channels as non-negative signed operands
  assign chan[0] = $signed({1'b0, red});
  assign chan[1] = $signed({1'b0, green});
  assign chan[2] = $signed({1'b0, blue});

  // one constant multiplier per weight
  for (genvar k = 0; k < NUM_COEF; k++) begin : g_mul
    localparam longint FIX = to_fixed(COEF_DEC[k], COEF_FRAC_BITS);
    localparam logic signed [CW-1:0] COEF = CW'(FIX);
    assign prod_nxt[k] = PW'(COEF) * PW'(chan[k % 3]);
  end

  // stage handshake
  assign up_ready  = !valid_r || dn_ready;
  assign load      = up_valid && up_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign prod     = prod_r;

endmodule

### hw/rtl/dcs_sum_stage.sv
// second pipeline stage: three-term sums, half-plane test, matrix row select
// uses dcs_pkg for group indexes
module dcs_sum_stage #(
  parameter int COEF_FRAC_BITS = 16,
  parameter int PW = COEF_FRAC_BITS + 11,
  parameter int SW = PW + 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [PW-1:0] prod [dcs_pkg::NUM_COEF],
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic signed [SW-1:0] sum [3],
  output logic                 plane
);
  import dcs_pkg::*;

  logic                 valid_r;
  logic                 valid_nxt;
  logic                 load;
  logic signed [SW-1:0] grp [NUM_GROUP];
  logic                 use475;
  logic signed [SW-1:0] sum_nxt [3];
  logic signed [SW-1:0] sum_r [3];
  logic                 plane_r;

  // dot products of every row
  for (genvar g = 0; g < NUM_GROUP; g++) begin : g_add
    assign grp[g] = SW'(prod[3*g]) + SW'(prod[3*g+1]) + SW'(prod[3*g+2]);
  end

  // ties go to the 475 nm side
  assign use475 = !(grp[GRP_SQLE] < grp[GRP_SELQ]);

  for (genvar r = 0; r < 3; r++) begin : g_sel
    assign sum_nxt[r] = use475 ? grp[GRP_M475 + r] : grp[GRP_M575 + r];
  end

  // stage handshake
  assign up_ready  = !valid_r || dn_ready;
  assign load      = up_valid && up_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_r   <= sum_nxt;
      plane_r <= use475;
    end
  end

  assign dn_valid = valid_r;
  assign sum      = sum_r;
  assign plane    = plane_r;

endmodule

### hw/rtl/dcs_finish_stage.sv
// last pipeline stage: round, floor and clamp each channel into the output register
// standalone, width parameters come from the top level
module dcs_finish_stage #(
  parameter int COEF_FRAC_BITS = 16,
  parameter int SW = COEF_FRAC_BITS + 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [SW-1:0] sum [3],
  input  logic                 plane,
  output logic                 dn_valid,
  input  logic                 dn_ready,
  output logic [7:0]           chan [3],
  output logic                 plane_out
);

  localparam int F = COEF_FRAC_BITS;
  localparam logic signed [SW:0] HALF = (SW+1)'(longint'(1) << (F - 1));

  logic             valid_r;
  logic             valid_nxt;
  logic             load;
  logic signed [SW:0] rnd [3];
  logic [7:0]       chan_nxt [3];
  logic [7:0]       chan_r [3];
  logic             plane_r;

  // add one half, floor by dropping fraction bits, clamp to 0..255
  for (genvar c = 0; c < 3; c++) begin : g_clamp
    assign rnd[c] = (SW+1)'(sum[c]) + HALF;
    always_comb begin
      if (rnd[c][SW]) begin
        chan_nxt[c] = 8'd0;
      end else if (|rnd[c][SW-1:F+8]) begin
        chan_nxt[c] = 8'd255;
      end else begin
        chan_nxt[c] = rnd[c][F+7:F];
      end
    end
  end

  // output register handshake
  assign up_ready  = !valid_r || dn_ready;
  assign load      = up_valid && up_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chan_r  <= chan_nxt;
      plane_r <= plane;
    end
  end

  assign dn_valid  = valid_r;
  assign chan      = chan_r;
  assign plane_out = plane_r;

endmodule

### hw/rtl/dichromat_color_simulation.sv
// top level of the deuteranopia color simulation pipeline
// uses dcs_pkg, dcs_mul_stage, dcs_sum_stage and dcs_finish_stage
//
// usage:
//   input channel: in_red_in, in_green_in, in_blue_in with in_valid; a transfer
//   happens on a rising edge with in_valid high and in_stall low.
//   result channel: out_red_out, out_green_out, out_blue_out and out_plane_used
//   (0 = 575 nm matrix, 1 = 475 nm matrix) with out_valid and out_stall.
//   each input color gives exactly one result, in order.
// pipeline: three register stages (product, sum/select, round/clamp); an accepted
//   color is registered in the product, sum and output registers in that order,
//   and the result transfers when out_valid is high and out_stall is low.
// throughput: one color per cycle while out_stall stays low; every stage holds one item.
// stall: each stage keeps its item while the next one is full and stalled;
//   in_stall rises only when all three stages hold items and out_stall is high.
//   out_valid comes straight from the output register.
// reset: synchronous, active low; clears all stage valid bits, the pipeline
//   starts empty and accepts input in the first cycle after reset.
module dichromat_color_simulation #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic       out_plane_used
);
  import dcs_pkg::*;

  localparam int PW = COEF_FRAC_BITS + 11;
  localparam int SW = PW + 2;

  logic                 mul_ready;
  logic                 mul_valid;
  logic signed [PW-1:0] prod [NUM_COEF];
  logic                 sum_ready;
  logic                 sum_valid;
  logic signed [SW-1:0] sum [3];
  logic                 plane;
  logic                 fin_ready;
  logic [7:0]           chan [3];

  // constant products
  dcs_mul_stage #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .PW             (PW)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (mul_ready),
    .red      (in_red_in),
    .green    (in_green_in),
    .blue     (in_blue_in),
    .dn_valid (mul_valid),
    .dn_ready (sum_ready),
    .prod     (prod)
  );

  // sums and half-plane select
  dcs_sum_stage #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .PW             (PW),
    .SW             (SW)
  ) u_sum (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mul_valid),
    .up_ready (sum_ready),
    .prod     (prod),
    .dn_valid (sum_valid),
    .dn_ready (fin_ready),
    .sum      (sum),
    .plane    (plane)
  );

  // round, clamp and output register
  dcs_finish_stage #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .SW             (SW)
  ) u_fin (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (sum_valid),
    .up_ready  (fin_ready),
    .sum       (sum),
    .plane     (plane),
    .dn_valid  (out_valid),
    .dn_ready  (!out_stall),
    .chan      (chan),
    .plane_out (out_plane_used)
  );

  assign in_stall      = !mul_ready;
  assign out_red_out   = chan[0];
  assign out_green_out = chan[1];
  assign out_blue_out  = chan[2];

  // input stalls only with every stage full and the output stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (mul_valid && sum_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  // an item leaving the product stage lands in the sum stage
  a_mul_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_valid && sum_ready) |=> sum_valid)
    else $error("item lost between product and sum stages");

  // an item leaving the sum stage lands in the output register
  a_sum_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (sum_valid && fin_ready) |=> out_valid)
    else $error("item lost between sum stage and output register");

endmodule

### dv/dcs_color_checker.sv
`timescale 1ns / 100ps
// checker for the dichromat color simulation: watches both channels and
// predicts each simulated color from its own fixed-point copy of the weights
// depends on nothing but the port widths of dichromat_color_simulation
module dcs_color_checker #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_red_out,
  input  logic [7:0] out_green_out,
  input  logic [7:0] out_blue_out,
  input  logic       out_plane_used,
  output int         fail_count,
  output int         pending,
  output int         checked,
  output int         side475
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       plane;
  } sim_color_t;

  localparam longint WEIGHT_SCALE = 64'sd100000000;

  // plane projections, decimal weights scaled by 1e8
  localparam longint SQLE_W [3] = '{64'sd999000, 64'sd6647390, 64'sd73170000};
  localparam longint SELQ_W [3] = '{64'sd15338400, 64'sd31662400, 64'sd5713400};

  // half-plane matrices, row major, r g b columns
  localparam longint M575_W [9] = '{
    64'sd42633100,  64'sd87510200, 64'sd8012710,
    64'sd28110000,  64'sd57119500, -64'sd3926270,
    -64'sd1770520,  64'sd2700840,  64'sd100247000
  };
  localparam longint M475_W [9] = '{
    64'sd75810000,  64'sd145387000, -64'sd148060000,
    64'sd11853200,  64'sd28759500,  64'sd72550100,
    -64'sd746579,   64'sd4487110,   64'sd95430300
  };

  sim_color_t expected_colors[$];

  // decimal weight to fixed point, halves go away from zero
  function automatic longint fixed_weight(longint w);
    longint mag;
    longint q;
    mag = (w < 0) ? -w : w;
    q = (mag * (64'sd1 <<< COEF_FRAC_BITS) + WEIGHT_SCALE / 2) / WEIGHT_SCALE;
    return (w < 0) ? -q : q;
  endfunction

  // add one half, floor, clamp to a byte
  function automatic logic [7:0] round_clamp(longint acc);
    longint v;
    v = acc + (64'sd1 <<< (COEF_FRAC_BITS - 1));
    if (v < 0) return 8'd0;
    v = v >>> COEF_FRAC_BITS;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic sim_color_t simulate_dichromat(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint ch [3];
    longint sqle;
    longint selq;
    longint acc;
    logic [7:0] chan [3];
    sim_color_t res;
    ch[0] = longint'(r);
    ch[1] = longint'(g);
    ch[2] = longint'(b);
    sqle = 0;
    selq = 0;
    for (int i = 0; i < 3; i++) begin
      sqle += fixed_weight(SQLE_W[i]) * ch[i];
      selq += fixed_weight(SELQ_W[i]) * ch[i];
    end
    // a tie goes to the 475 nm side
    res.plane = !(sqle < selq);
    for (int k = 0; k < 3; k++) begin
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        acc += fixed_weight(res.plane ? M475_W[k * 3 + i] : M575_W[k * 3 + i]) * ch[i];
      end
      chan[k] = round_clamp(acc);
    end
    res.red = chan[0];
    res.green = chan[1];
    res.blue = chan[2];
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
    side475 = 0;
  end

  // everything is driven at the rising edge, so the falling edge sees the
  // values that decide the next transfer
  always @(negedge clk) begin
    sim_color_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("result with nothing pending, red", out_red_out, -1);
        end else begin
          want = expected_colors.pop_front();
          checked++;
          if (out_plane_used) side475++;
          if (out_red_out !== want.red) report_mismatch("red", out_red_out, want.red);
          if (out_green_out !== want.green) report_mismatch("green", out_green_out, want.green);
          if (out_blue_out !== want.blue) report_mismatch("blue", out_blue_out, want.blue);
          if (out_plane_used !== want.plane)
            report_mismatch("plane", out_plane_used, want.plane);
        end
      end
      if (in_valid && !in_stall) begin
        expected_colors.push_back(simulate_dichromat(in_red_in, in_green_in, in_blue_in));
      end
      pending = expected_colors.size();
    end
  end

endmodule

### dv/dichromat_color_simulation_test.sv
`timescale 1ns / 100ps
// top of the dichromat color simulation testbench: clock, reset, stimulus,
// receiver stalls and verdict; uses dichromat_color_simulation and dcs_color_checker
module dichromat_color_simulation_test;

  localparam int FRAC_BITS = 16;
  localparam int RANDOM_PER_PHASE = 300;
  localparam int CYCLE_LIMIT = 400000;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_red_in = 8'd0;
  logic [7:0] in_green_in = 8'd0;
  logic [7:0] in_blue_in = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;
  logic       out_plane_used;

  int fail_count;
  int pending;
  int checked;
  int side475;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  // directed colors: black (plane tie), white, primaries, clamp cases, near boundary
  localparam logic [23:0] DIRECTED [20] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
    24'hFFFF00, 24'hFF00FF, 24'h00FFFF, 24'h808080, 24'h010101,
    24'hFEFEFE, 24'hFF8000, 24'h000001, 24'h010000, 24'h000100,
    24'hC8320A, 24'h0A32C8, 24'h001B0A, 24'h001B0B, 24'h55AA55
  };

  dichromat_color_simulation #(.COEF_FRAC_BITS(FRAC_BITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_plane_used(out_plane_used)
  );

  dcs_color_checker #(.COEF_FRAC_BITS(FRAC_BITS)) chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_plane_used(out_plane_used),
    .fail_count(fail_count), .pending(pending), .checked(checked), .side475(side475)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // random receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // run guard
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // one color transfer with an optional random gap in front
  task automatic send_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  function automatic logic [7:0] edge_byte();
    case ($urandom_range(4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      3: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // random color: uniform, channel extremes, or close to the plane boundary
  task automatic send_random_color();
    logic [7:0] r;
    logic [7:0] g;
    int b;
    int mode;
    mode = $urandom_range(9);
    r = 8'($urandom_range(255));
    g = 8'($urandom_range(255));
    b = $urandom_range(255);
    if (mode == 7) begin
      r = edge_byte();
      g = edge_byte();
      b = edge_byte();
    end else if (mode >= 8) begin
      // blue that roughly balances the two projections
      b = (1434 * r + 2500 * g) / 6746 + $urandom_range(4) - 2;
      if (b < 0) b = 0;
      if (b > 255) b = 255;
    end
    send_color(r, g, 8'(b));
  endtask

  initial begin
    int gaps [4];
    int stalls [4];
    gaps = '{0, 70, 0, 18};
    stalls = '{0, 0, 70, 18};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed colors with no idling
    foreach (DIRECTED[i]) begin
      send_color(DIRECTED[i][23:16], DIRECTED[i][15:8], DIRECTED[i][7:0]);
    end

    // random colors under each idle mix
    for (int p = 0; p < 4; p++) begin
      send_gap_pct = gaps[p];
      recv_stall_pct = stalls[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_random_color();
      end
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    // drain the pipeline
    while (pending != 0) @(negedge clk);
    repeat (10) @(posedge clk);

    $display("checked %0d colors (%0d on the 475 nm side) over four idle mixes,",
             checked, side475);
    $display("with extremes, clamp cases and near-boundary colors; %0d mismatches",
             fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
